[rtl/assert_macros.svh]
// Shared assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/tts_pkg.sv]
package tts_pkg;

  localparam int DEPTH = 16;
  localparam int VALUE_W = 32;

  localparam logic [1:0] FUNC_PUSH  = 2'd0;
  localparam logic [1:0] FUNC_POP   = 2'd1;
  localparam logic [1:0] FUNC_MERGE = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // One store entry as held by a cell.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               tag;
    logic               valid;
  } slot_t;

  // Operation broadcast to every cell in the row.
  typedef struct packed {
    logic push;
    logic pop;
    logic merge;
    logic sel;
  } cmd_t;

endpackage

[rtl/tts_cell.sv]
module tts_cell (
  input  logic          clk,
  input  logic          rst,
  input  tts_pkg::cmd_t cmd,
  input  tts_pkg::slot_t newer,
  input  tts_pkg::slot_t older,
  input  logic          hit_in,
  output tts_pkg::slot_t slot,
  output logic          hit_out,
  output logic          take
);

  tts_pkg::slot_t slot_next;
  logic           match;
  logic           close_up;

  assign match    = slot.valid && (slot.tag == cmd.sel);
  assign hit_out  = hit_in || match;
  assign take     = cmd.pop && match && !hit_in;
  // at or behind the popped entry: pull from the older neighbor
  assign close_up = cmd.pop && (hit_in || match);

  always_comb begin
    slot_next = slot;
    priority if (cmd.push) begin
      slot_next = newer;
    end else if (close_up) begin
      slot_next = older;
    end else if (cmd.merge && slot.valid) begin
      slot_next.tag = cmd.sel;
    end
  end

  // only the valid bit is reset; value and tag are don't-care while invalid
  always_ff @(posedge clk) begin
    slot.value <= slot_next.value;
    slot.tag   <= slot_next.tag;
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot.valid <= slot_next.valid;
    end
  end

endmodule

[rtl/tagged_two_stack_with_merge_top.sv]
// Two tagged stacks (A = 0, B = 1) sharing one store of tts_pkg::DEPTH entries,
// kept newest first in a row of cells. A beat is taken whenever start is high
// (busy is always low), and its result appears on pop_value/status with done
// high in the next cycle, for that one cycle only; the receiver cannot stall
// it, so capture it when done is seen. This rests on the cell row: the newest
// matching entry is found by a hit chain rippling through the cells, and all
// cells shift in the same edge. Push shifts the row one cell older; pop closes
// the gap behind the removed entry; merge retags all valid entries to the
// named stack.
// status: 0 ok, 1 pop found the stack empty (pop_value 0), 2 push dropped
// because the store is full. Push, merge and func code 3 return pop_value 0;
// code 3 changes nothing.
module tagged_two_stack_with_merge_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic               stack_sel,
  input  logic signed [31:0] push_value,
  output logic               done,
  output logic signed [31:0] pop_value,
  output logic [1:0]         status
);

  tts_pkg::cmd_t  cmd;
  tts_pkg::slot_t slots [tts_pkg::DEPTH];
  tts_pkg::slot_t newer [tts_pkg::DEPTH];
  tts_pkg::slot_t older [tts_pkg::DEPTH];
  logic [tts_pkg::DEPTH:0]   hit;
  logic [tts_pkg::DEPTH-1:0] take;
  logic                      full;
  logic [tts_pkg::VALUE_W-1:0] found;

  logic signed [31:0] pop_value_next;
  logic [1:0]         status_next;

  assign busy = 1'b0;

  // store is full when the oldest cell holds an entry
  assign full = slots[tts_pkg::DEPTH-1].valid;

  always_comb begin
    cmd.push  = start && (func == tts_pkg::FUNC_PUSH) && !full;
    cmd.pop   = start && (func == tts_pkg::FUNC_POP);
    cmd.merge = start && (func == tts_pkg::FUNC_MERGE);
    cmd.sel   = stack_sel;
  end

  assign hit[0] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < tts_pkg::DEPTH; g++) begin : g_cell
      // newest cell takes the pushed entry
      if (g == 0) begin : g_head
        assign newer[g] = '{value: $unsigned(push_value), tag: stack_sel, valid: 1'b1};
      end else begin : g_mid
        assign newer[g] = slots[g-1];
      end
      // oldest cell empties when the row closes up
      if (g == tts_pkg::DEPTH - 1) begin : g_tail
        assign older[g] = '{value: '0, tag: 1'b0, valid: 1'b0};
      end else begin : g_body
        assign older[g] = slots[g+1];
      end

      tts_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .cmd     (cmd),
        .newer   (newer[g]),
        .older   (older[g]),
        .hit_in  (hit[g]),
        .slot    (slots[g]),
        .hit_out (hit[g+1]),
        .take    (take[g])
      );
    end
  endgenerate

  // at most one cell flags take, so an AND-OR picks the popped value
  always_comb begin
    found = '0;
    for (int i = 0; i < tts_pkg::DEPTH; i++) begin
      found = found | (slots[i].value & {tts_pkg::VALUE_W{take[i]}});
    end
  end

  always_comb begin
    pop_value_next = '0;
    status_next    = tts_pkg::STATUS_OK;
    if (cmd.pop) begin
      if (hit[tts_pkg::DEPTH]) begin
        pop_value_next = $signed(found);
      end else begin
        status_next = tts_pkg::STATUS_EMPTY;
      end
    end else if (start && (func == tts_pkg::FUNC_PUSH) && full) begin
      status_next = tts_pkg::STATUS_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    pop_value <= pop_value_next;
    status    <= status_next;
  end

endmodule

[rtl/tts_checker.sv]
`include "assert_macros.svh"

module tts_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [1:0]         func,
  input logic               done,
  input logic signed [31:0] pop_value,
  input logic [1:0]         status
);

  logic beat;
  logic status_ok;
  logic nonpop_clean;

  assign beat         = start && !busy;
  assign status_ok    = (status == tts_pkg::STATUS_OK);
  assign nonpop_clean = (pop_value == 0) && (status != tts_pkg::STATUS_EMPTY);

  // every accepted beat gives exactly one result on the next cycle
  `ASSERT_NEXT(a_done_follows, clk, rst, beat, done)
  `ASSERT_NEXT(a_no_stray_done, clk, rst, !beat, !done)

  // a non-ok result never carries a value
  `ASSERT_SAME(a_fail_zero, clk, rst, done && !status_ok, pop_value == 0)

  // only pops return data; merge always succeeds
  `ASSERT_NEXT(a_nonpop_zero, clk, rst, beat && (func != tts_pkg::FUNC_POP), nonpop_clean)
  `ASSERT_NEXT(a_merge_ok, clk, rst, beat && (func == tts_pkg::FUNC_MERGE), status_ok)

endmodule

bind tagged_two_stack_with_merge_top tts_checker u_tts_checker (.*);

[bench/tb_tagged_two_stack_with_merge_top.sv]
`timescale 1ns / 1ps

module tb_tagged_two_stack_with_merge_top;

  localparam int DEPTH = tts_pkg::DEPTH;

  localparam logic [1:0] FUNC_PUSH  = tts_pkg::FUNC_PUSH;
  localparam logic [1:0] FUNC_POP   = tts_pkg::FUNC_POP;
  localparam logic [1:0] FUNC_MERGE = tts_pkg::FUNC_MERGE;

  localparam logic [1:0] STATUS_OK    = tts_pkg::STATUS_OK;
  localparam logic [1:0] STATUS_EMPTY = tts_pkg::STATUS_EMPTY;
  localparam logic [1:0] STATUS_FULL  = tts_pkg::STATUS_FULL;

  // func code 3 has no name in the package: it must leave the store alone
  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam logic STACK_A = 1'b0;
  localparam logic STACK_B = 1'b1;

  localparam int RANDOM_BEATS = 1125;
  localparam int STALL_LIMIT = 5000;   // cycles with no beat and no result
  localparam int DRAIN_CYCLES = 4;     // spare edges after the last result is in
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } op_result_t;

  // One row of the directed plan. reps > 1 repeats the row, value + k on
  // the k-th copy. Rows with known_want carry their result typed in.
  typedef struct {
    logic [1:0]         op;
    logic               sel;
    logic signed [31:0] value;
    int                 reps;
    bit                 known_want;
    logic signed [31:0] want_value;
    logic [1:0]         want_status;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         func = FUNC_PUSH;
  logic               stack_sel = STACK_A;
  logic signed [31:0] push_value = '0;
  logic               done;
  logic signed [31:0] pop_value;
  logic [1:0]         status;

  // typed-in expectation travels with the beat it belongs to
  logic               pinned_valid = 1'b0;
  op_result_t         pinned_want = '0;

  // shadow of the shared store, slot 0 oldest
  logic signed [31:0] shadow_val [DEPTH];
  logic               shadow_tag [DEPTH];
  int                 shadow_fill = 0;

  op_result_t         owed_results [$];
  int                 mismatches = 0;
  int                 idle_cycles = 0;

  tagged_two_stack_with_merge_top dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .stack_sel  (stack_sel),
    .push_value (push_value),
    .done       (done),
    .pop_value  (pop_value),
    .status     (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Walk the shadow store through one command and return what the block owes.
  function automatic op_result_t apply_stack_op(logic [1:0] op, logic sel,
                                                logic signed [31:0] v);
    op_result_t r;
    int hit;
    int i;
    r.value = '0;
    r.status = STATUS_OK;
    hit = -1;
    case (op)
      FUNC_PUSH: begin
        if (shadow_fill >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          shadow_val[shadow_fill] = v;
          shadow_tag[shadow_fill] = sel;
          shadow_fill++;
        end
      end
      FUNC_POP: begin
        // newest match wins
        for (i = shadow_fill - 1; i >= 0; i--) begin
          if (hit < 0 && shadow_tag[i] == sel) hit = i;
        end
        if (hit < 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.value = shadow_val[hit];
          // close the gap, push order kept
          for (i = hit; i < shadow_fill - 1; i++) begin
            shadow_val[i] = shadow_val[i + 1];
            shadow_tag[i] = shadow_tag[i + 1];
          end
          shadow_fill--;
        end
      end
      FUNC_MERGE: begin
        // every live entry ends up on the receiving stack
        for (i = 0; i < shadow_fill; i++) shadow_tag[i] = sel;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic log_mismatch(input string why, input op_result_t want,
                              input op_result_t got);
    if (mismatches < MAX_REPORTS)
      $display("[%0t] %s: expected value %0d status %0d, got value %0d status %0d",
               $realtime, why, want.value, want.status, got.value, got.status);
    mismatches++;
  endtask

  // Monitor: results at this edge belong to beats taken at earlier edges, so
  // they are checked before the beat of this edge is predicted.
  always @(posedge clk) begin : monitor
    op_result_t want;
    op_result_t got;
    logic moved;
    if (!rst) begin
      moved = 1'b0;
      if (done) begin
        moved = 1'b1;
        got.value = pop_value;
        got.status = status;
        if (owed_results.size() == 0) begin
          log_mismatch("result with nothing owed", '0, got);
        end else begin
          want = owed_results.pop_front();
          if (got.value !== want.value || got.status !== want.status)
            log_mismatch("result mismatch", want, got);
        end
      end
      if (start && !busy) begin
        moved = 1'b1;
        // predictor always runs so the shadow store stays in step
        want = apply_stack_op(func, stack_sel, push_value);
        if (pinned_valid) want = pinned_want;
        owed_results.push_back(want);
      end
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("watchdog: %0d idle cycles, %0d results owed",
                   idle_cycles, owed_results.size());
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  // Present one beat after an optional gap and hold it until it is taken.
  // start gets a single NBA per step: lowered only when a gap follows.
  task automatic send_beat(input logic [1:0] op, input logic sel,
                           input logic signed [31:0] v, input bit pinned,
                           input op_result_t want, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    func <= op;
    stack_sel <= sel;
    push_value <= v;
    pinned_valid <= pinned;
    pinned_want <= want;
    do @(posedge clk); while (busy);
  endtask

  // mostly back to back, some short gaps, rare long ones
  function automatic int pick_gap(bit flat_out);
    int r;
    r = $urandom_range(99);
    if (flat_out || r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(15))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sh0000_0000;
      3: return 32'shFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Directed opening: empty pops, no-op codes, extremes, a fill past full.
  plan_row_t plan [12] = '{
    '{FUNC_POP,   STACK_A, 32'sh0,         1,  1'b1, 32'sh0,         STATUS_EMPTY},
    '{FUNC_MERGE, STACK_B, 32'sh0,         1,  1'b1, 32'sh0,         STATUS_OK},
    '{FUNC_NOP,   STACK_A, 32'sh1234_5678, 1,  1'b1, 32'sh0,         STATUS_OK},
    '{FUNC_PUSH,  STACK_A, 32'sh7FFF_FFFF, 1,  1'b1, 32'sh0,         STATUS_OK},
    '{FUNC_PUSH,  STACK_B, 32'sh8000_0000, 1,  1'b1, 32'sh0,         STATUS_OK},
    '{FUNC_POP,   STACK_A, 32'sh0,         1,  1'b1, 32'sh7FFF_FFFF, STATUS_OK},
    // store not empty, but nothing tagged A
    '{FUNC_POP,   STACK_A, 32'sh0,         1,  1'b1, 32'sh0,         STATUS_EMPTY},
    '{FUNC_MERGE, STACK_A, 32'sh0,         1,  1'b0, 32'sh0,         STATUS_OK},
    // fills the store to DEPTH, then one push too many
    '{FUNC_PUSH,  STACK_A, 32'shFFFF_FFF0, 15, 1'b0, 32'sh0,         STATUS_OK},
    '{FUNC_PUSH,  STACK_B, 32'sh5A5A_A5A5, 1,  1'b1, 32'sh0,         STATUS_FULL},
    '{FUNC_MERGE, STACK_B, 32'sh0,         1,  1'b0, 32'sh0,         STATUS_OK},
    '{FUNC_POP,   STACK_A, 32'sh0,         1,  1'b1, 32'sh0,         STATUS_EMPTY}
  };

  initial begin : stimulus
    op_result_t want;
    logic [1:0] op;
    logic sel;
    int sent;
    int seg_len;
    int push_pct;
    int b_pct;
    int r;
    bit flat_out;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[row]) begin
      want.value = plan[row].want_value;
      want.status = plan[row].want_status;
      for (int k = 0; k < plan[row].reps; k++)
        send_beat(plan[row].op, plan[row].sel, plan[row].value + k,
                  plan[row].known_want, want, pick_gap(1'b0));
    end

    // Random part in segments, each with its own push bias and stack bias so
    // the store swings between empty, full and in between.
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      seg_len = $urandom_range(75, 25);
      case ($urandom_range(2))
        0: push_pct = 20;
        1: push_pct = 50;
        default: push_pct = 80;
      endcase
      b_pct = $urandom_range(2) * 40 + 10;
      flat_out = ($urandom_range(3) == 0);

      // sender holds off until every owed result is in; always on the first
      if (sent == 0 || $urandom_range(3) == 0) begin
        start <= 1'b0;
        @(posedge clk);
        while (owed_results.size() != 0) @(posedge clk);
      end

      for (int k = 0; k < seg_len && sent < RANDOM_BEATS; k++) begin
        r = $urandom_range(99);
        if (r < push_pct) begin
          op = FUNC_PUSH;
        end else begin
          r = $urandom_range(99);
          if (r < 75) op = FUNC_POP;
          else if (r < 95) op = FUNC_MERGE;
          else op = FUNC_NOP;
        end
        sel = ($urandom_range(99) < b_pct) ? STACK_B : STACK_A;
        send_beat(op, sel, pick_value(), 1'b0, '0, pick_gap(flat_out));
        sent++;
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
